// ===== hdl/weighted_running_statistics_defines.svh =====
// Assertion macros used by the top level to check this block.
`ifndef WEIGHTED_RUNNING_STATISTICS_DEFINES_SVH
`define WEIGHTED_RUNNING_STATISTICS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRS_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WRS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/wrs_pkg.sv =====
// Shared types, constants and codes of the weighted running statistics block.
`timescale 1ns / 1ps
package wrs_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int WEIGHT_FRAC_BITS_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Operand register of the shared divide and root unit, left aligned.
	localparam int OPND_BITS = 80;
	localparam int STEP_BITS = 7;
	// Mean: 48-bit magnitude with nine extra quotient bits.
	localparam logic [STEP_BITS-1:0] MEAN_STEPS = STEP_BITS'(57);
	// Mean square: 64-bit sum of squares with nine extra quotient bits.
	localparam logic [STEP_BITS-1:0] MS_STEPS = STEP_BITS'(73);
	// A 64-bit root takes two radicand bits per step.
	localparam logic [STEP_BITS-1:0] ROOT_STEPS = STEP_BITS'(32);

	localparam logic signed [24:0] RMS_EMPTY = -25'sd256;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_ZERO_WEIGHT = 2'd2,
		ST_REJECTED = 2'd3
	} wrs_status_t;

	typedef enum logic {
		OP_DIV = 1'b0,
		OP_ROOT = 1'b1
	} wrs_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MEAN,
		S_MS,
		S_SQUARE,
		S_VAR,
		S_SD,
		S_SE_DIV,
		S_SE_ROOT,
		S_RMS,
		S_EMIT
	} wrs_state_t;

	// Accumulator state after one item, as handed from front to back.
	typedef struct packed {
		logic        empty;
		logic        rejected;
		logic [15:0] count;
		logic [15:0] min_value;
		logic [15:0] max_value;
		logic [47:0] sum;
		logic [63:0] sum_sq;
		logic [31:0] weight;
	} wrs_snap_t;

	typedef struct packed {
		logic                  start;
		wrs_op_t               op;
		logic [OPND_BITS-1:0]  operand;
		logic [STEP_BITS-1:0]  steps;
		logic [31:0]           divisor;
	} wrs_unit_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} wrs_unit_rsp_t;

endpackage

// ===== hdl/wrs_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps
interface wrs_in_if;
	logic               valid;
	logic               ready;
	logic               clear_first;
	logic               has_sample;
	logic signed [15:0] sample;
	logic [15:0]        weight;

	modport source(output valid, clear_first, has_sample, sample, weight, input ready);
	modport sink(input valid, clear_first, has_sample, sample, weight, output ready);
endinterface

interface wrs_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        count;
	logic signed [15:0] min_value;
	logic signed [15:0] max_value;
	logic signed [47:0] weighted_sum;
	logic [62:0]        weighted_sum_sq;
	logic [31:0]        total_weight;
	logic signed [24:0] mean_value;
	logic signed [39:0] variance_value;
	logic [23:0]        std_dev;
	logic [27:0]        std_error;
	logic signed [24:0] rms_value;
	logic [1:0]         status;

	modport source(output valid, count, min_value, max_value, weighted_sum, weighted_sum_sq,
		total_weight, mean_value, variance_value, std_dev, std_error, rms_value, status,
		input ready);
	modport sink(input valid, count, min_value, max_value, weighted_sum, weighted_sum_sq,
		total_weight, mean_value, variance_value, std_dev, std_error, rms_value, status,
		output ready);
endinterface

// ===== hdl/wrs_front.sv =====
// Front end: accepts items, forms the products and updates the accumulators.
`timescale 1ns / 1ps
module wrs_front #(
	parameter int SAMPLE_BITS = wrs_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS = wrs_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	wrs_in_if.sink            samples,
	input  logic              full,
	output logic              push,
	output wrs_pkg::wrs_snap_t push_data
);
	localparam int SQ_BITS = 2 * SAMPLE_BITS;
	localparam int SW_BITS = SAMPLE_BITS + 17;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic                          valid_s1, valid_s2;
	logic                          clear_s1, clear_s2, has_s1, has_s2;
	logic signed [SAMPLE_BITS-1:0] s_s1, s_s2;
	logic [15:0]                   w_s1, w_s2;
	logic signed [SW_BITS-1:0]     sw_s2;
	logic [SQ_BITS-1:0]            sq_s2;

	logic [COUNT_BITS-1:0]         cnt_q;
	logic [31:0]                   wt_q;
	logic [47:0]                   sum_q;
	logic [63:0]                   sum_sq_q;
	logic signed [SAMPLE_BITS-1:0] min_q, max_q;

	logic signed [SW_BITS-1:0]     sw_c;
	logic signed [SQ_BITS-1:0]     sq_c;
	logic [63:0]                   sqw_c;
	logic [COUNT_BITS-1:0]         cnt_b, cnt_n;
	logic [31:0]                   wt_b, wt_n;
	logic [47:0]                   sum_b, sum_n;
	logic [63:0]                   sum_sq_b, sum_sq_n;
	logic signed [SAMPLE_BITS-1:0] min_n, max_n;
	logic                          reject, take;

	// One item in flight at a time; the queue must have room for its snapshot.
	assign samples.ready = !valid_s1 && !valid_s2 && !full;

	assign sw_c = s_s1 * $signed({1'b0, w_s1});
	assign sq_c = s_s1 * s_s1;
	assign sqw_c = sq_s2 * w_s2;

	always_comb begin
		cnt_b = clear_s2 ? '0 : cnt_q;
		wt_b = clear_s2 ? '0 : wt_q;
		sum_b = clear_s2 ? '0 : sum_q;
		sum_sq_b = clear_s2 ? '0 : sum_sq_q;
		reject = has_s2 && (cnt_b == CNT_MAX);
		take = has_s2 && !reject;
		cnt_n = cnt_b;
		wt_n = wt_b;
		sum_n = sum_b;
		sum_sq_n = sum_sq_b;
		min_n = min_q;
		max_n = max_q;
		if (take) begin
			cnt_n = cnt_b + 1'b1;
			wt_n = wt_b + 32'(w_s2);
			sum_n = sum_b + 48'(sw_s2);
			sum_sq_n = sum_sq_b + sqw_c;
			if (cnt_b == '0 || s_s2 < min_q) begin
				min_n = s_s2;
			end
			if (cnt_b == '0 || s_s2 > max_q) begin
				max_n = s_s2;
			end
		end
	end

	assign push = valid_s2;
	always_comb begin
		push_data.empty = (cnt_n == '0);
		push_data.rejected = reject;
		push_data.count = 16'(cnt_n);
		push_data.min_value = (cnt_n == '0) ? 16'd0 : 16'(min_n);
		push_data.max_value = (cnt_n == '0) ? 16'd0 : 16'(max_n);
		push_data.sum = sum_n;
		push_data.sum_sq = sum_sq_n;
		push_data.weight = wt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			cnt_q <= '0;
			wt_q <= '0;
			sum_q <= '0;
			sum_sq_q <= '0;
		end else begin
			valid_s1 <= samples.valid && samples.ready;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				cnt_q <= cnt_n;
				wt_q <= wt_n;
				sum_q <= sum_n;
				sum_sq_q <= sum_sq_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			clear_s1 <= samples.clear_first;
			has_s1 <= samples.has_sample;
			s_s1 <= SAMPLE_BITS'(samples.sample);
			w_s1 <= samples.weight;
		end
		if (valid_s1) begin
			clear_s2 <= clear_s1;
			has_s2 <= has_s1;
			s_s2 <= s_s1;
			w_s2 <= w_s1;
			sw_s2 <= sw_c;
			sq_s2 <= sq_c;
		end
		if (valid_s2) begin
			min_q <= min_n;
			max_q <= max_n;
		end
	end
endmodule

// ===== hdl/wrs_queue.sv =====
// Short snapshot queue between front end and back end.
`timescale 1ns / 1ps
module wrs_queue #(
	parameter int DEPTH = wrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wrs_pkg::wrs_snap_t push_data,
	output logic               full,
	input  logic               pop,
	output wrs_pkg::wrs_snap_t pop_data,
	output logic               nonempty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	wrs_pkg::wrs_snap_t entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   fill_q;

	assign full = (fill_q == DEPTH_C);
	assign nonempty = (fill_q != '0);
	assign pop_data = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end
endmodule

// ===== hdl/wrs_divsqrt.sv =====
// Shared serial unit: restoring division one bit a cycle, square root two bits a cycle.
`timescale 1ns / 1ps
module wrs_divsqrt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wrs_pkg::wrs_unit_req_t req,
	output wrs_pkg::wrs_unit_rsp_t rsp
);
	logic                                busy_q, done_q;
	wrs_pkg::wrs_op_t                    op_q;
	logic [wrs_pkg::OPND_BITS-1:0]       opnd_q;
	logic [35:0]                         rem_q, shifted, trial, rem_n;
	logic [63:0]                         q_q;
	logic [31:0]                         den_q;
	logic [wrs_pkg::STEP_BITS-1:0]       cnt_q;
	logic                                bit_n;

	always_comb begin
		if (op_q == wrs_pkg::OP_ROOT) begin
			shifted = {rem_q[33:0], opnd_q[wrs_pkg::OPND_BITS-1 -: 2]};
			trial = {2'b00, q_q[31:0], 2'b01};
		end else begin
			shifted = {rem_q[34:0], opnd_q[wrs_pkg::OPND_BITS-1]};
			trial = {4'd0, den_q};
		end
		bit_n = (shifted >= trial);
		rem_n = bit_n ? shifted - trial : shifted;
	end

	// A root is rounded up when the remainder exceeds the root.
	always_comb begin
		rsp.done = done_q;
		if (op_q == wrs_pkg::OP_ROOT) begin
			rsp.result = 64'(q_q[31:0]) + 64'(rem_q > 36'(q_q[31:0]));
		end else begin
			rsp.result = q_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == wrs_pkg::STEP_BITS'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == wrs_pkg::STEP_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			opnd_q <= req.operand;
			den_q <= req.divisor;
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_n;
			q_q <= {q_q[62:0], bit_n};
			opnd_q <= (op_q == wrs_pkg::OP_ROOT) ? {opnd_q[wrs_pkg::OPND_BITS-3:0], 2'b00}
				: {opnd_q[wrs_pkg::OPND_BITS-2:0], 1'b0};
		end
	end
endmodule

// ===== hdl/wrs_back.sv =====
// Back end: sequences the divisions and roots of one snapshot and holds the result item.
`timescale 1ns / 1ps
module wrs_back #(
	parameter int WEIGHT_FRAC_BITS = wrs_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   nonempty,
	input  wrs_pkg::wrs_snap_t     pop_data,
	output logic                   pop,
	output wrs_pkg::wrs_unit_req_t req,
	input  wrs_pkg::wrs_unit_rsp_t rsp,
	wrs_out_if.source              results
);
	localparam logic [wrs_pkg::STEP_BITS-1:0] SE_STEPS =
		wrs_pkg::STEP_BITS'(40 + WEIGHT_FRAC_BITS + 8);

	wrs_pkg::wrs_state_t state_q, state_d;
	logic                launch_q;
	wrs_pkg::wrs_snap_t  snap_q;
	logic [63:0]         mmag_q, ms_q, prod_q, se_quo_q, round_c, msq_c;
	logic [39:0]         var_q, v0;
	logic [23:0]         sd_q;
	logic [27:0]         se_q;
	logic [24:0]         rms_q;
	logic [47:0]         mag;
	logic                neg;

	logic                out_valid_q;
	logic [15:0]         count_q, min_q, max_q;
	logic [47:0]         wsum_q;
	logic [62:0]         wsum_sq_q;
	logic [31:0]         twt_q;
	logic [24:0]         mean_q, rms_out_q;
	logic [39:0]         var_out_q;
	logic [23:0]         sd_out_q;
	logic [27:0]         se_out_q;
	logic [1:0]          status_q;

	assign neg = snap_q.sum[47];
	assign mag = neg ? -snap_q.sum : snap_q.sum;
	assign v0 = var_q[39] ? '0 : var_q;
	// Halve a quotient that carries one extra bit, rounding half up.
	assign round_c = rsp.result + 64'd1;
	assign msq_c = (prod_q + 64'd128) >> 8;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wrs_pkg::S_IDLE: begin
				if (nonempty) begin
					state_d = (pop_data.empty || pop_data.weight == '0)
						? wrs_pkg::S_EMIT : wrs_pkg::S_MEAN;
				end
			end
			wrs_pkg::S_MEAN: if (rsp.done) state_d = wrs_pkg::S_MS;
			wrs_pkg::S_MS: if (rsp.done) state_d = wrs_pkg::S_SQUARE;
			wrs_pkg::S_SQUARE: state_d = wrs_pkg::S_VAR;
			wrs_pkg::S_VAR: state_d = wrs_pkg::S_SD;
			wrs_pkg::S_SD: if (rsp.done) state_d = wrs_pkg::S_SE_DIV;
			wrs_pkg::S_SE_DIV: if (rsp.done) state_d = wrs_pkg::S_SE_ROOT;
			wrs_pkg::S_SE_ROOT: if (rsp.done) state_d = wrs_pkg::S_RMS;
			wrs_pkg::S_RMS: if (rsp.done) state_d = wrs_pkg::S_EMIT;
			wrs_pkg::S_EMIT: if (!out_valid_q || results.ready) state_d = wrs_pkg::S_IDLE;
			default: state_d = wrs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == wrs_pkg::S_IDLE) && nonempty;
		req.start = launch_q;
		req.op = wrs_pkg::OP_ROOT;
		req.operand = '0;
		req.steps = wrs_pkg::ROOT_STEPS;
		req.divisor = snap_q.weight;
		unique case (state_q)
			wrs_pkg::S_MEAN: begin
				req.op = wrs_pkg::OP_DIV;
				req.operand = {mag, 32'd0};
				req.steps = wrs_pkg::MEAN_STEPS;
			end
			wrs_pkg::S_MS: begin
				req.op = wrs_pkg::OP_DIV;
				req.operand = {snap_q.sum_sq, 16'd0};
				req.steps = wrs_pkg::MS_STEPS;
			end
			wrs_pkg::S_SD: req.operand = {16'd0, v0, 8'd0, 16'd0};
			wrs_pkg::S_SE_DIV: begin
				req.op = wrs_pkg::OP_DIV;
				req.operand = {v0, 40'd0};
				req.steps = SE_STEPS;
			end
			wrs_pkg::S_SE_ROOT: req.operand = {se_quo_q, 16'd0};
			wrs_pkg::S_RMS: req.operand = {ms_q[55:0], 8'd0, 16'd0};
			default: req.operand = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wrs_pkg::S_IDLE;
			launch_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			launch_q <= (state_d != state_q) && (state_d == wrs_pkg::S_MEAN
				|| state_d == wrs_pkg::S_MS || state_d == wrs_pkg::S_SD
				|| state_d == wrs_pkg::S_SE_DIV || state_d == wrs_pkg::S_SE_ROOT
				|| state_d == wrs_pkg::S_RMS);
			if (state_q == wrs_pkg::S_EMIT && (!out_valid_q || results.ready)) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			wrs_pkg::S_IDLE: begin
				if (nonempty) begin
					snap_q <= pop_data;
					mmag_q <= '0;
					var_q <= '0;
					sd_q <= '0;
					se_q <= '0;
					rms_q <= '0;
				end
			end
			wrs_pkg::S_MEAN: if (rsp.done) mmag_q <= {1'b0, round_c[63:1]};
			wrs_pkg::S_MS: if (rsp.done) ms_q <= {1'b0, round_c[63:1]};
			wrs_pkg::S_SQUARE: prod_q <= mmag_q[31:0] * mmag_q[31:0];
			wrs_pkg::S_VAR: var_q <= 40'(ms_q - msq_c);
			wrs_pkg::S_SD: if (rsp.done) sd_q <= 24'(rsp.result);
			wrs_pkg::S_SE_DIV: if (rsp.done) se_quo_q <= rsp.result;
			wrs_pkg::S_SE_ROOT: if (rsp.done) se_q <= 28'(rsp.result);
			wrs_pkg::S_RMS: if (rsp.done) rms_q <= 25'(rsp.result);
			wrs_pkg::S_EMIT: begin
				if (!out_valid_q || results.ready) begin
					count_q <= snap_q.count;
					min_q <= snap_q.min_value;
					max_q <= snap_q.max_value;
					wsum_q <= snap_q.sum;
					wsum_sq_q <= snap_q.sum_sq[62:0];
					twt_q <= snap_q.weight;
					mean_q <= neg ? -mmag_q[24:0] : mmag_q[24:0];
					var_out_q <= var_q;
					sd_out_q <= sd_q;
					se_out_q <= se_q;
					rms_out_q <= snap_q.empty ? wrs_pkg::RMS_EMPTY : rms_q;
					priority if (snap_q.rejected) status_q <= wrs_pkg::ST_REJECTED;
					else if (snap_q.empty) status_q <= wrs_pkg::ST_EMPTY;
					else if (snap_q.weight == '0) status_q <= wrs_pkg::ST_ZERO_WEIGHT;
					else status_q <= wrs_pkg::ST_OK;
				end
			end
			default: ;
		endcase
	end

	assign results.valid = out_valid_q;
	assign results.count = count_q;
	assign results.min_value = min_q;
	assign results.max_value = max_q;
	assign results.weighted_sum = wsum_q;
	assign results.weighted_sum_sq = wsum_sq_q;
	assign results.total_weight = twt_q;
	assign results.mean_value = mean_q;
	assign results.variance_value = var_out_q;
	assign results.std_dev = sd_out_q;
	assign results.std_error = se_out_q;
	assign results.rms_value = rms_out_q;
	assign results.status = status_q;
endmodule

// ===== hdl/weighted_running_statistics.sv =====
// Top level of the weighted running statistics block.
`timescale 1ns / 1ps
// Weighted running statistics. Each input item may clear the accumulators and
// may add one signed sample with an unsigned Q8.8 weight; every item yields one
// result item with the count, min, max, weighted sums, total weight and the
// Q.8 mean, variance, standard deviation, standard error and RMS. A front end
// takes one item at a time, forms the products, updates the accumulators and
// pushes a snapshot into a short queue. The back end works on one snapshot at
// a time with a single shared serial unit that divides one quotient bit per
// cycle and takes roots two radicand bits per cycle; this unit sets the rate.
// A nonempty set with nonzero total weight runs three divisions (mean, mean
// square, standard error) and three roots (standard deviation, standard error,
// RMS) on that unit, with the square of the mean and the variance formed in
// between; an empty set or a set of zero total weight skips all of them. The
// result sits in an output register, so the back end starts the next snapshot
// while the previous result waits. Empty sets report an RMS of -1.0, and a
// sample arriving at the count limit is dropped with status 3.
`include "weighted_running_statistics_defines.svh"
module weighted_running_statistics #(
	parameter int SAMPLE_BITS = wrs_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS = wrs_pkg::COUNT_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = wrs_pkg::WEIGHT_FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = wrs_pkg::QUEUE_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	wrs_in_if.sink    samples,
	wrs_out_if.source results
);
	logic                   q_push, q_full, q_pop, q_nonempty;
	wrs_pkg::wrs_snap_t     q_push_data, q_pop_data;
	wrs_pkg::wrs_unit_req_t unit_req;
	wrs_pkg::wrs_unit_rsp_t unit_rsp;

	// Accepts items and keeps the accumulators.
	wrs_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.full(q_full),
		.push(q_push),
		.push_data(q_push_data)
	);

	// Decouples the two halves so each can stall on its own.
	wrs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_push_data),
		.full(q_full),
		.pop(q_pop),
		.pop_data(q_pop_data),
		.nonempty(q_nonempty)
	);

	// Derives the statistics of one snapshot and holds the result item.
	wrs_back #(
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.nonempty(q_nonempty),
		.pop_data(q_pop_data),
		.pop(q_pop),
		.req(unit_req),
		.rsp(unit_rsp),
		.results(results)
	);

	// The one divider and root extractor that all the divisions and roots share.
	wrs_divsqrt u_divsqrt (
		.clk(clk),
		.arst_n(arst_n),
		.req(unit_req),
		.rsp(unit_rsp)
	);

	// The front end never pushes a snapshot the queue cannot hold.
	`WRS_ASSERT_NOW(a_no_push_when_full, q_push, !q_full, "snapshot pushed into a full queue")
	// After an item is taken the front end holds off the next one while it works.
	`WRS_ASSERT_NEXT(a_accept_then_busy, samples.valid && samples.ready, !samples.ready, "front end took items back to back")
	// An empty set always reports an RMS of -1.0.
	`WRS_ASSERT_NOW(a_empty_rms, results.valid && results.status == wrs_pkg::ST_EMPTY, results.rms_value == wrs_pkg::RMS_EMPTY, "empty set without RMS of -1.0")
	// The back end only takes a snapshot from a queue that holds one.
	`WRS_ASSERT_NOW(a_pop_nonempty, q_pop, q_nonempty, "snapshot taken from an empty queue")
endmodule

// ===== dv/weighted_running_statistics_test.sv =====
// Self-checking testbench for the weighted running statistics block.
`timescale 1ns / 1ps
module weighted_running_statistics_test;

	localparam int unsigned CYCLE_LIMIT = 5000000;
	localparam int unsigned DRAIN_CYCLES = 400;
	localparam logic [15:0] COUNT_CEILING = 16'hFFFF;
	localparam logic [15:0] UNIT_WEIGHT = 16'd256;

	// One input item as the sender drives it.
	typedef struct {
		logic               clear_first;
		logic               has_sample;
		logic signed [15:0] sample;
		logic [15:0]        weight;
	} stat_item_t;

	// One result item, at the widths of the output channel.
	typedef struct {
		logic [15:0]          count;
		logic signed [15:0]   min_value;
		logic signed [15:0]   max_value;
		logic signed [47:0]   weighted_sum;
		logic [62:0]          weighted_sum_sq;
		logic [31:0]          total_weight;
		logic signed [24:0]   mean_value;
		logic signed [39:0]   variance_value;
		logic [23:0]          std_dev;
		logic [27:0]          std_error;
		logic signed [24:0]   rms_value;
		wrs_pkg::wrs_status_t status;
	} stat_report_t;

	logic clk;
	logic arst_n;

	wrs_in_if  sample_ch();
	wrs_out_if report_ch();

	weighted_running_statistics i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(sample_ch.sink),
		.results(report_ch.source)
	);

	// Clock with a 20 ns period.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	stat_item_t   pending_items[$];
	stat_report_t expected_reports[$];
	int unsigned  error_count;
	int unsigned  cycle_count;
	int unsigned  send_gap;
	int unsigned  take_gap;
	// When set, neither side inserts gaps: a stretch with no idling.
	bit           steady_run;

	// Shadow accumulators that mirror the block's state.
	logic [15:0]        acc_count;
	logic [31:0]        acc_weight;
	logic [47:0]        acc_sum;
	logic [63:0]        acc_sum_sq;
	logic signed [15:0] acc_min;
	logic signed [15:0] acc_max;

	// floor(num * 2^sh / den), kept to 64 bits.
	function automatic logic [63:0] scaled_quotient(logic [63:0] num, int sh, logic [31:0] den);
		logic [127:0] wide;
		wide = {64'd0, num} << sh;
		return 64'(wide / {96'd0, den});
	endfunction

	// Square root rounded to nearest: floor root, plus one above the midpoint.
	function automatic logic [63:0] rounded_root(logic [63:0] x);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= x) begin
				root = trial;
			end
		end
		if (x - root * root > root) begin
			root = root + 64'd1;
		end
		return root;
	endfunction

	// Applies one accepted item to the shadow state and works out its result.
	function automatic stat_report_t accumulate_item(stat_item_t it);
		stat_report_t rep;
		logic         dropped;
		longint       s;
		longint       w;
		logic         negative;
		logic [63:0]  magnitude;
		logic [63:0]  mean_mag;
		logic [63:0]  mean_sq;
		logic [63:0]  square_of_mean;
		logic [39:0]  var40;
		logic [63:0]  var_clamped;
		dropped = 1'b0;
		if (it.clear_first) begin
			acc_count = '0;
			acc_weight = '0;
			acc_sum = '0;
			acc_sum_sq = '0;
		end
		if (it.has_sample) begin
			if (acc_count == COUNT_CEILING) begin
				dropped = 1'b1;
			end else begin
				s = longint'(it.sample);
				w = longint'({48'd0, it.weight});
				if (acc_count == 0) begin
					acc_min = it.sample;
					acc_max = it.sample;
				end else begin
					if (it.sample < acc_min) acc_min = it.sample;
					if (it.sample > acc_max) acc_max = it.sample;
				end
				acc_sum = acc_sum + 48'(s * w);
				acc_sum_sq = acc_sum_sq + 64'(s * s * w);
				acc_weight = acc_weight + {16'd0, it.weight};
				acc_count = acc_count + 16'd1;
			end
		end
		rep.count = acc_count;
		rep.min_value = (acc_count != 0) ? acc_min : '0;
		rep.max_value = (acc_count != 0) ? acc_max : '0;
		rep.weighted_sum = acc_sum;
		rep.weighted_sum_sq = acc_sum_sq[62:0];
		rep.total_weight = acc_weight;
		rep.mean_value = '0;
		rep.variance_value = '0;
		rep.std_dev = '0;
		rep.std_error = '0;
		rep.rms_value = '0;
		rep.status = wrs_pkg::ST_OK;
		if (acc_count == 0) begin
			rep.rms_value = wrs_pkg::RMS_EMPTY;
			rep.status = wrs_pkg::ST_EMPTY;
		end else if (acc_weight == 0) begin
			rep.status = wrs_pkg::ST_ZERO_WEIGHT;
		end else begin
			negative = acc_sum[47];
			magnitude = {16'd0, negative ? (48'd0 - acc_sum) : acc_sum};
			// One extra quotient bit, then round half up on the magnitude.
			mean_mag = (scaled_quotient(magnitude, 9, acc_weight) + 64'd1) >> 1;
			mean_sq = (scaled_quotient(acc_sum_sq, 9, acc_weight) + 64'd1) >> 1;
			square_of_mean = (mean_mag * mean_mag + 64'd128) >> 8;
			var40 = 40'(mean_sq - square_of_mean);
			// A variance driven negative by rounding counts as zero for the roots.
			var_clamped = var40[39] ? 64'd0 : {24'd0, var40};
			rep.mean_value = 25'(negative ? (64'd0 - mean_mag) : mean_mag);
			rep.variance_value = var40;
			rep.std_dev = 24'(rounded_root(var_clamped << 8));
			rep.std_error = 28'(rounded_root(scaled_quotient(var_clamped, 16, acc_weight)));
			rep.rms_value = 25'(rounded_root(mean_sq << 8));
		end
		if (dropped) begin
			rep.status = wrs_pkg::ST_REJECTED;
		end
		return rep;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("Mismatch on %s: got 0x%0h, expected 0x%0h (t=%0t)", field, got, want, $time);
		error_count++;
	endtask

	// Most gaps are short, a few are long, none during a steady stretch.
	function automatic int unsigned pick_gap();
		if (steady_run) return 0;
		if ($urandom_range(0, 11) == 0) return $urandom_range(15, 60);
		return $urandom_range(0, 2);
	endfunction

	// Sender: holds an item until it is taken, then pulls the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.clear_first <= 1'b0;
			sample_ch.has_sample <= 1'b0;
			sample_ch.sample <= '0;
			sample_ch.weight <= '0;
			send_gap <= 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				expected_reports.push_back(accumulate_item('{sample_ch.clear_first,
					sample_ch.has_sample, sample_ch.sample, sample_ch.weight}));
			end
			if (!sample_ch.valid || sample_ch.ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					sample_ch.valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					stat_item_t nxt;
					nxt = pending_items.pop_front();
					sample_ch.valid <= 1'b1;
					sample_ch.clear_first <= nxt.clear_first;
					sample_ch.has_sample <= nxt.has_sample;
					sample_ch.sample <= nxt.sample;
					sample_ch.weight <= nxt.weight;
					send_gap <= pick_gap();
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every taken result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_ch.ready <= 1'b0;
			take_gap <= 0;
		end else begin
			if (report_ch.valid && report_ch.ready) begin
				if (expected_reports.size() == 0) begin
					$display("Unexpected result item (t=%0t)", $time);
					error_count++;
				end else begin
					stat_report_t want;
					want = expected_reports.pop_front();
					if (report_ch.count !== want.count)
						report_mismatch("count", 64'(report_ch.count), 64'(want.count));
					if (report_ch.min_value !== want.min_value)
						report_mismatch("min_value", 64'(report_ch.min_value), 64'(want.min_value));
					if (report_ch.max_value !== want.max_value)
						report_mismatch("max_value", 64'(report_ch.max_value), 64'(want.max_value));
					if (report_ch.weighted_sum !== want.weighted_sum)
						report_mismatch("weighted_sum", 64'(report_ch.weighted_sum),
							64'(want.weighted_sum));
					if (report_ch.weighted_sum_sq !== want.weighted_sum_sq)
						report_mismatch("weighted_sum_sq", 64'(report_ch.weighted_sum_sq),
							64'(want.weighted_sum_sq));
					if (report_ch.total_weight !== want.total_weight)
						report_mismatch("total_weight", 64'(report_ch.total_weight),
							64'(want.total_weight));
					if (report_ch.mean_value !== want.mean_value)
						report_mismatch("mean_value", 64'(report_ch.mean_value), 64'(want.mean_value));
					if (report_ch.variance_value !== want.variance_value)
						report_mismatch("variance_value", 64'(report_ch.variance_value),
							64'(want.variance_value));
					if (report_ch.std_dev !== want.std_dev)
						report_mismatch("std_dev", 64'(report_ch.std_dev), 64'(want.std_dev));
					if (report_ch.std_error !== want.std_error)
						report_mismatch("std_error", 64'(report_ch.std_error), 64'(want.std_error));
					if (report_ch.rms_value !== want.rms_value)
						report_mismatch("rms_value", 64'(report_ch.rms_value), 64'(want.rms_value));
					if (report_ch.status !== want.status)
						report_mismatch("status", 64'(report_ch.status), 64'(want.status));
				end
			end
			if (take_gap != 0) begin
				take_gap <= take_gap - 1;
				report_ch.ready <= 1'b0;
			end else begin
				report_ch.ready <= 1'b1;
				if (report_ch.valid && report_ch.ready) begin
					take_gap <= pick_gap();
				end
			end
		end
	end

	// Watchdog and the switch between idling and steady stretches.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if ($urandom_range(0, 299) == 0) begin
			steady_run <= ($urandom_range(0, 3) == 0);
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic queue_item(logic clr, logic has, logic signed [15:0] smp, logic [15:0] wgt);
		stat_item_t it;
		it.clear_first = clr;
		it.has_sample = has;
		it.sample = smp;
		it.weight = wgt;
		pending_items.push_back(it);
	endtask

	// Waits at a falling edge until everything sent has come back.
	task automatic wait_all_returned();
		do @(negedge clk);
		while (pending_items.size() != 0 || sample_ch.valid || expected_reports.size() != 0);
	endtask

	// Random sample value: sometimes an extreme, sometimes a narrow spread so the
	// variance stays small and its rounding matters, most often any value.
	function automatic logic signed [15:0] random_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'(signed'($urandom_range(0, 8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] random_weight();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'hFFFF;
			2, 3: return UNIT_WEIGHT;
			4: return 16'($urandom_range(1, 8));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		error_count = 0;
		cycle_count = 0;
		steady_run = 1'b0;
		acc_count = '0;
		acc_weight = '0;
		acc_sum = '0;
		acc_sum_sq = '0;
		acc_min = '0;
		acc_max = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items: empty reports, extremes, zero weight, clears, halves.
		queue_item(1'b0, 1'b0, 16'sh0000, 16'h0000);
		queue_item(1'b1, 1'b0, 16'sh7FFF, 16'hFFFF);
		queue_item(1'b0, 1'b1, 16'sh8000, 16'h0000);
		queue_item(1'b0, 1'b1, 16'sh7FFF, 16'h0000);
		queue_item(1'b0, 1'b1, 16'sh8000, 16'hFFFF);
		queue_item(1'b0, 1'b1, 16'sh7FFF, 16'h0001);
		queue_item(1'b0, 1'b0, 16'sh1234, 16'h5678);
		queue_item(1'b1, 1'b1, 16'sh7FFF, 16'hFFFF);
		queue_item(1'b0, 1'b1, 16'sh7FFF, 16'hFFFF);
		queue_item(1'b1, 1'b1, -16'sd1, 16'h0080);
		queue_item(1'b0, 1'b1, 16'sh0000, 16'h0080);
		queue_item(1'b1, 1'b1, 16'sh0001, UNIT_WEIGHT);
		queue_item(1'b0, 1'b1, 16'sh0002, UNIT_WEIGHT);
		queue_item(1'b0, 1'b1, 16'sh0003, 16'h0003);
		queue_item(1'b1, 1'b1, 16'sh0005, 16'h0001);
		queue_item(1'b0, 1'b1, -16'sd5, 16'h0003);
		queue_item(1'b1, 1'b0, 16'sh0000, 16'h0000);

		// Random part, in two halves with a full drain between them.
		for (int half = 0; half < 2; half++) begin
			for (int n = 0; n < 800; n++) begin
				logic clr;
				logic has;
				clr = ($urandom_range(0, 39) == 0);
				has = ($urandom_range(0, 7) != 0);
				queue_item(clr, has, random_sample(), random_weight());
			end
			wait_all_returned();
		end

		queue_item(1'b0, 1'b1, 16'sh8000, 16'hFFFF);
		queue_item(1'b0, 1'b0, 16'sh0000, 16'h0000);
		queue_item(1'b0, 1'b1, 16'sh7FFF, UNIT_WEIGHT);
		queue_item(1'b1, 1'b1, 16'sh0007, UNIT_WEIGHT);
		queue_item(1'b0, 1'b1, -16'sd7, UNIT_WEIGHT);

		wait_all_returned();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
